>>> hdl/sha1md_pkg.sv
// Package: shared types, codes and constants of the SHA-1 message digest block.
`default_nettype none

package sha1md_pkg;

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 80;

  localparam logic [31:0] K_0 = 32'h5a827999;
  localparam logic [31:0] K_1 = 32'h6ed9eba1;
  localparam logic [31:0] K_2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_3 = 32'hca62c1d6;

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [31:0] PAD_WORD   = {PAD_BYTE, 24'h000000};
  localparam logic [2:0]  FULL_BYTES = 3'd4;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } sha1md_state_t;

  // Source of a word shifted into the block buffer
  typedef enum logic [2:0] {
    SRC_INPUT,
    SRC_PAD80,
    SRC_ZERO,
    SRC_LEN_HI,
    SRC_LEN_LO
  } sha1md_src_t;

  typedef struct packed {
    logic        push;
    sha1md_src_t src;
    logic        count_en;
    logic        round_en;
    logic        chain_add;
    logic        out_shift;
  } sha1md_cmd_t;

  typedef struct packed {
    logic in_last;
    logic in_full;
    logic fill_14;
    logic fill_15;
    logic round_last;
    logic out_last;
  } sha1md_stat_t;

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] w;
    unique case (idx)
      3'd0:    w = 32'h67452301;
      3'd1:    w = 32'hefcdab89;
      3'd2:    w = 32'h98badcfe;
      3'd3:    w = 32'h10325476;
      default: w = 32'hc3d2e1f0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hdl/sha1md_ctrl.sv
// Controller: sequences loading, padding, rounds, chaining and digest output.
`default_nettype none

module sha1md_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  input  sha1md_pkg::sha1md_stat_t stat,
  output sha1md_pkg::sha1md_cmd_t  cmd
);

  sha1md_pkg::sha1md_state_t state, state_next;
  logic pad_mode, pad_mode_next;
  logic extra_pad, extra_pad_next;
  logic len_phase, len_phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha1md_pkg::ST_LOAD;
      pad_mode  <= 1'b0;
      extra_pad <= 1'b0;
      len_phase <= 1'b0;
    end else begin
      state     <= state_next;
      pad_mode  <= pad_mode_next;
      extra_pad <= extra_pad_next;
      len_phase <= len_phase_next;
    end
  end

  always_comb begin
    state_next     = state;
    pad_mode_next  = pad_mode;
    extra_pad_next = extra_pad;
    len_phase_next = len_phase;
    s_tready       = 1'b0;
    m_tvalid       = 1'b0;
    cmd            = '0;
    cmd.src        = sha1md_pkg::SRC_ZERO;
    unique case (state)
      sha1md_pkg::ST_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.push     = 1'b1;
          cmd.src      = sha1md_pkg::SRC_INPUT;
          cmd.count_en = 1'b1;
          if (stat.in_last) begin
            pad_mode_next  = 1'b1;
            extra_pad_next = stat.in_full;
          end
          if (stat.fill_15) begin
            state_next = sha1md_pkg::ST_ROUND;
          end else if (stat.in_last) begin
            state_next = sha1md_pkg::ST_PAD;
          end
        end
      end
      sha1md_pkg::ST_PAD: begin
        cmd.push = 1'b1;
        priority if (extra_pad) begin
          cmd.src        = sha1md_pkg::SRC_PAD80;
          extra_pad_next = 1'b0;
        end else if (stat.fill_14) begin
          cmd.src        = sha1md_pkg::SRC_LEN_HI;
          len_phase_next = 1'b1;
        end else if (stat.fill_15 && len_phase) begin
          cmd.src = sha1md_pkg::SRC_LEN_LO;
        end else begin
          cmd.src = sha1md_pkg::SRC_ZERO;
        end
        if (stat.fill_15) begin
          state_next = sha1md_pkg::ST_ROUND;
        end
      end
      sha1md_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (stat.round_last) begin
          state_next = sha1md_pkg::ST_ADD;
        end
      end
      sha1md_pkg::ST_ADD: begin
        cmd.chain_add = 1'b1;
        priority if (len_phase) begin
          state_next = sha1md_pkg::ST_OUT;
        end else if (pad_mode) begin
          state_next = sha1md_pkg::ST_PAD;
        end else begin
          state_next = sha1md_pkg::ST_LOAD;
        end
      end
      sha1md_pkg::ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          cmd.out_shift = 1'b1;
          if (stat.out_last) begin
            state_next     = sha1md_pkg::ST_LOAD;
            pad_mode_next  = 1'b0;
            extra_pad_next = 1'b0;
            len_phase_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = sha1md_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/sha1md_dp.sv
// Datapath: block buffer and schedule, round logic, chaining value and length count.
`default_nettype none

module sha1md_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  sha1md_pkg::sha1md_cmd_t  cmd,
  output sha1md_pkg::sha1md_stat_t stat,
  input  logic [31:0]              in_word,
  input  logic [2:0]               in_valid,
  input  logic                     in_last,
  output logic [31:0]              out_word,
  output logic                     out_last
);

  logic [31:0] sched [sha1md_pkg::BLOCK_WORDS];
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [6:0]  rnd;
  logic [3:0]  fill;
  logic [60:0] byte_count;
  logic [2:0]  out_idx;

  logic [2:0]  v_sat;
  logic [31:0] last_word_val;
  logic [31:0] push_word;
  logic [2:0]  count_inc;
  logic [31:0] f, k, temp, sched_xor, sched_new;

  assign v_sat = (in_valid > sha1md_pkg::FULL_BYTES) ? sha1md_pkg::FULL_BYTES : in_valid;

  // Keep the valid leading bytes and place the pad byte right after them
  always_comb begin
    unique case (v_sat[1:0])
      2'd0:    last_word_val = sha1md_pkg::PAD_WORD;
      2'd1:    last_word_val = {in_word[31:24], sha1md_pkg::PAD_BYTE, 16'h0000};
      2'd2:    last_word_val = {in_word[31:16], sha1md_pkg::PAD_BYTE, 8'h00};
      default: last_word_val = {in_word[31:8], sha1md_pkg::PAD_BYTE};
    endcase
    if (!in_last || (v_sat == sha1md_pkg::FULL_BYTES)) begin
      last_word_val = in_word;
    end
  end

  always_comb begin
    unique case (cmd.src)
      sha1md_pkg::SRC_INPUT:  push_word = last_word_val;
      sha1md_pkg::SRC_PAD80:  push_word = sha1md_pkg::PAD_WORD;
      sha1md_pkg::SRC_LEN_HI: push_word = byte_count[60:29];
      sha1md_pkg::SRC_LEN_LO: push_word = {byte_count[28:0], 3'b000};
      default:                push_word = '0;
    endcase
  end

  assign count_inc = in_last ? v_sat : sha1md_pkg::FULL_BYTES;

  always_comb begin
    priority if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = sha1md_pkg::K_0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = sha1md_pkg::K_1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1md_pkg::K_2;
    end else begin
      f = b ^ c ^ d;
      k = sha1md_pkg::K_3;
    end
  end

  assign temp      = {a[26:0], a[31:27]} + f + e + k + sched[0];
  assign sched_xor = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
  assign sched_new = {sched_xor[30:0], sched_xor[31]};

  // Control state, chaining value and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) begin
        h[i] <= sha1md_pkg::init_word(3'(i));
      end
      rnd        <= '0;
      fill       <= '0;
      byte_count <= '0;
      out_idx    <= '0;
    end else begin
      if (cmd.push) begin
        fill <= fill + 4'd1;
      end
      if (cmd.count_en) begin
        byte_count <= byte_count + {58'd0, count_inc};
      end
      if (cmd.round_en) begin
        rnd <= (rnd == 7'(sha1md_pkg::ROUNDS - 1)) ? 7'd0 : rnd + 7'd1;
      end
      if (cmd.chain_add) begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
        h[4] <= h[4] + e;
      end
      if (cmd.out_shift) begin
        for (int i = 0; i < 4; i++) begin
          h[i] <= h[i + 1];
        end
        h[4] <= sha1md_pkg::init_word(out_idx);
        if (out_idx == 3'd4) begin
          out_idx    <= '0;
          byte_count <= '0;
        end else begin
          out_idx <= out_idx + 3'd1;
        end
      end
    end
  end

  // Block buffer doubles as the message schedule; working variables
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int i = 0; i < sha1md_pkg::BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[sha1md_pkg::BLOCK_WORDS - 1] <= push_word;
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (cmd.round_en) begin
      for (int i = 0; i < sha1md_pkg::BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[sha1md_pkg::BLOCK_WORDS - 1] <= sched_new;
      a <= temp;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  assign stat.in_last    = in_last;
  assign stat.in_full    = (v_sat == sha1md_pkg::FULL_BYTES);
  assign stat.fill_14    = (fill == 4'd14);
  assign stat.fill_15    = (fill == 4'd15);
  assign stat.round_last = (rnd == 7'(sha1md_pkg::ROUNDS - 1));
  assign stat.out_last   = (out_idx == 3'd4);

  assign out_word = h[0];
  assign out_last = (out_idx == 3'd4);

endmodule

`default_nettype wire

>>> hdl/sha1_message_digest.sv
// Top level: SHA-1 message digest over a stream of 32-bit big-endian words.
`default_nettype none

// Send the message as 32-bit words on the s_ stream, first byte in bits 31..24, and
// mark the final word with s_tlast; its s_tuser gives the count of valid leading bytes
// (0 to 4, larger values count as 4; ignored on other words). The block takes one word
// per cycle until a 64-byte block is buffered, then runs the 80 SHA-1 rounds at one
// round per cycle in a single shared round unit, then folds the result into the
// chaining value. After the last word, padding and the 64-bit length are shifted in
// one word per cycle, taking one or two final blocks. The five digest words then
// appear on the m_ stream, H0 first, the fifth marked by m_tlast, and the block
// starts over from the initial chaining value. No input is taken while rounds run or
// the digest is being sent.

module sha1_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] message_word
  input  logic [2:0]  s_tuser,   // [2:0] valid_bytes
  input  logic        s_tlast,   // last_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic        m_tlast    // last_digest_word
);

  sha1md_pkg::sha1md_cmd_t  cmd;
  sha1md_pkg::sha1md_stat_t stat;

  // Sequence load, pad, rounds, chain update and digest output
  sha1md_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the block, run the round unit, hold the chaining value and length
  sha1md_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_word  (s_tdata),
    .in_valid (s_tuser),
    .in_last  (s_tlast),
    .out_word (m_tdata),
    .out_last (m_tlast)
  );

  // Input and output sides never run in the same cycle
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(m_tvalid && s_tready))
    else $error("input ready while digest output is pending");

  // A final word always leads to padding or rounds, never straight to another word
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input accepted right after the final word");

  // After the fifth digest word the block is ready for a new message
  a_restart: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("block did not restart after the last digest word");

endmodule

`default_nettype wire

>>> test/sha1_message_digest_tb.sv
// Testbench: SHA-1 digests of directed and random word streams, checked against a predictor.
`timescale 1ns / 100ps

module sha1_message_digest_tb;

  localparam int unsigned IDLE_MAX      = 18;
  localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no request moving on either side
  localparam int unsigned HOLD_OFF      = 300;   // long receiver stall to back up the input
  localparam int unsigned RANDOM_WORDS  = 390;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned DIRECTED_ROWS = 20;
  localparam int unsigned MSG_BLOCK_WORDS = 16;
  localparam int unsigned LEN_SLOT      = 14;    // first word of the 64-bit length field

  localparam logic [159:0] SHA1_IV =
    160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;
  localparam logic [31:0] SHA1_PAD_WORD = 32'h80000000;
  localparam logic [31:0] SHA1_PAD_BYTE = 32'h00000080;

  typedef struct packed {
    logic [31:0]  word;
    logic [2:0]   valid_bytes;
    logic         last_word;
    logic         has_known;
    logic [159:0] known_digest;  // H0 in the top bits
  } stim_row_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;

  sha1_message_digest DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Digest predictor: chaining value, partial block, and message length
  // ---------------------------------------------------------------------------
  logic [31:0]  hash_h [5];
  logic [31:0]  msg_block [MSG_BLOCK_WORDS];
  int unsigned  block_fill;
  logic [60:0]  msg_bytes;   // wraps like the hardware counter

  digest_beat_t expected_digest_q [$];
  int unsigned  error_count = 0;
  int unsigned  beats_seen = 0;
  int unsigned  stall_cycles = 0;
  bit           sender_idles = 1'b1;

  function automatic void restart_hash();
    int j;
    for (j = 0; j < 5; j++) hash_h[j] = SHA1_IV[159 - 32 * j -: 32];
    block_fill = 0;
    msg_bytes  = '0;
  endfunction

  function automatic logic [31:0] rotate_left(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] sched [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    int r;
    for (r = 0; r < 16; r++) sched[r] = msg_block[r];
    for (r = 16; r < 80; r++)
      sched[r] = rotate_left(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    e = hash_h[4];
    for (r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5a827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ed9eba1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8f1bbcdc;
      end else begin
        f = b ^ c ^ d;
        k = 32'hca62c1d6;
      end
      t = rotate_left(a, 5) + f + e + k + sched[r];
      e = d;
      d = c;
      c = rotate_left(b, 30);
      b = a;
      a = t;
    end
    hash_h[0] += a;
    hash_h[1] += b;
    hash_h[2] += c;
    hash_h[3] += d;
    hash_h[4] += e;
  endfunction

  function automatic void absorb_word(input logic [31:0] word);
    msg_block[block_fill] = word;
    block_fill++;
    if (block_fill == MSG_BLOCK_WORDS) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  // Fold one request into the running hash; on the last word return the digest.
  function automatic bit absorb_request(input logic [31:0] word, input logic [2:0] valid_bytes,
                                        input logic last_word, output logic [159:0] digest);
    int unsigned nb;
    logic [31:0] pad_word;
    logic [63:0] bit_len;
    int j;
    digest = '0;
    if (!last_word) begin
      // valid byte count means nothing here: a middle word is always four bytes
      absorb_word(word);
      msg_bytes = msg_bytes + 61'd4;
      return 1'b0;
    end
    nb = (valid_bytes > 3'd4) ? 4 : valid_bytes;
    msg_bytes = msg_bytes + nb;
    if (nb == 4) begin
      absorb_word(word);
      pad_word = SHA1_PAD_WORD;
    end else begin
      // drop the bytes past the valid count, put the pad byte right after them
      pad_word = (word & ~(32'hffffffff >> (8 * nb))) | (SHA1_PAD_BYTE << (24 - 8 * nb));
    end
    absorb_word(pad_word);
    // no room left for the length: zero out this block and start another
    if (block_fill > LEN_SLOT) begin
      while (block_fill != 0) absorb_word(32'h0);
    end
    while (block_fill < LEN_SLOT) absorb_word(32'h0);
    bit_len = {msg_bytes, 3'b000};
    absorb_word(bit_len[63:32]);
    absorb_word(bit_len[31:0]);
    for (j = 0; j < 5; j++) digest[159 - 32 * j -: 32] = hash_h[j];
    restart_hash();
    return 1'b1;
  endfunction

  // Mostly random words, with the all-zero and all-one extremes mixed in
  function automatic logic [31:0] biased_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 32'h00000000;
    if (pick == 1) return 32'hffffffff;
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: call at a falling edge, returns at the falling edge after acceptance
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [31:0] word, input logic [2:0] valid_bytes,
                              input logic last_word, input logic has_known,
                              input logic [159:0] known_digest);
    int unsigned  gap;
    logic [159:0] digest;
    digest_beat_t beat;
    int j;
    gap = sender_idles ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= valid_bytes;
    s_tlast  <= last_word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // request taken at this edge: queue the digest it completes, if any
    if (absorb_request(word, valid_bytes, last_word, digest)) begin
      if (has_known) digest = known_digest;
      for (j = 0; j < 5; j++) begin
        beat.word = digest[159 - 32 * j -: 32];
        beat.last = (j == 4);
        expected_digest_q.push_back(beat);
      end
    end
    @(negedge clk);
  endtask

  initial begin : stimulus
    stim_row_t   rows [DIRECTED_ROWS];
    int unsigned sent, n, mode, k;
    rows = '{
      // empty message: known digest, junk in the unused bytes
      '{32'hffffffff, 3'd0, 1'b1, 1'b1, 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709},
      // "abc" in a partial last word, trailing byte must be ignored
      '{32'h616263ff, 3'd3, 1'b1, 1'b1, 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d},
      // valid count above four saturates
      '{32'hffffffff, 3'd7, 1'b1, 1'b0, 160'h0},
      '{32'h00000000, 3'd4, 1'b1, 1'b0, 160'h0},
      '{32'hffffffff, 3'd1, 1'b1, 1'b0, 160'h0},
      '{32'h12345678, 3'd2, 1'b1, 1'b0, 160'h0},
      // thirteen middle words with stray valid counts, then a full last word:
      // the pad word lands in slot 14, so the length needs a second block
      '{32'h00000000, 3'd0, 1'b0, 1'b0, 160'h0},
      '{32'hffffffff, 3'd7, 1'b0, 1'b0, 160'h0},
      '{32'h00000000, 3'd4, 1'b0, 1'b0, 160'h0},
      '{32'hffffffff, 3'd1, 1'b0, 1'b0, 160'h0},
      '{32'ha5a5a5a5, 3'd2, 1'b0, 1'b0, 160'h0},
      '{32'h5a5a5a5a, 3'd3, 1'b0, 1'b0, 160'h0},
      '{32'hffffffff, 3'd5, 1'b0, 1'b0, 160'h0},
      '{32'h00000000, 3'd6, 1'b0, 1'b0, 160'h0},
      '{32'h01234567, 3'd0, 1'b0, 1'b0, 160'h0},
      '{32'h89abcdef, 3'd7, 1'b0, 1'b0, 160'h0},
      '{32'hfedcba98, 3'd4, 1'b0, 1'b0, 160'h0},
      '{32'h76543210, 3'd2, 1'b0, 1'b0, 160'h0},
      '{32'hffffffff, 3'd0, 1'b0, 1'b0, 160'h0},
      '{32'hdeadbeef, 3'd4, 1'b1, 1'b0, 160'h0}
    };
    restart_hash();
    wait (!rst);
    @(negedge clk);
    foreach (rows[i])
      send_request(rows[i].word, rows[i].valid_bytes, rows[i].last_word,
                   rows[i].has_known, rows[i].known_digest);

    // Random messages: mostly short, many ending near a block boundary,
    // a few spanning several blocks. Idle gaps come and go per message.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      mode = $urandom_range(0, 19);
      if (mode < 12) n = $urandom_range(0, 20);
      else if (mode < 17) n = 16 * $urandom_range(0, 1) + $urandom_range(12, 15);
      else n = $urandom_range(21, 70);
      // keep the total word count on budget
      if (n > RANDOM_WORDS - sent - 1) n = RANDOM_WORDS - sent - 1;
      for (k = 0; k < n; k++) begin
        send_request(biased_word(), 3'($urandom_range(0, 7)), 1'b0, 1'b0, 160'h0);
        sent++;
      end
      send_request(biased_word(), 3'($urandom_range(0, 7)), 1'b1, 1'b0, 160'h0);
      sent++;
    end
    s_tvalid <= 1'b0;

    // Hold until every digest is out, then watch a while for stray output
    while (expected_digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready gaps in stretches, plus long hold-offs in the middle
  // of a digest that back up the input while the sender keeps offering words
  // ---------------------------------------------------------------------------
  initial begin : digest_sink
    int unsigned gap;
    bit          rx_idles;
    rx_idles = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_idles = !rx_idles;
      gap = rx_idles ? $urandom_range(0, IDLE_MAX) : 0;
      if (beats_seen == 7 || beats_seen == 47) gap = HOLD_OFF;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Output check and watchdog, sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : digest_check
    digest_beat_t want;
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (m_tvalid && m_tready) begin
        beats_seen++;
        if (expected_digest_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected digest word, expected none, got %h last %b",
                   $time, m_tdata, m_tlast);
        end else begin
          want = expected_digest_q.pop_front();
          if (m_tdata !== want.word) begin
            error_count++;
            $display("%0t: digest word mismatch, expected %h, got %h",
                     $time, want.word, m_tdata);
          end
          if (m_tlast !== want.last) begin
            error_count++;
            $display("%0t: last digest word flag mismatch, expected %b, got %b",
                     $time, want.last, m_tlast);
          end
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, stall_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
